@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define RVL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication in the next cycle
`define RVL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/rvl_dd_pkg.sv @@
// shared types and constants of the depth image decompressor
package rvl_dd_pkg;

	localparam int WORD_BITS    = 32;
	localparam int NIB_BITS     = 4;
	localparam int NIBBLES      = WORD_BITS / NIB_BITS;
	localparam int NIB_IDX_BITS = $clog2(NIBBLES);
	localparam int PIXEL_BITS   = 16;
	localparam int COUNT_BITS   = 23;
	localparam int ACC_BITS     = 32;
	localparam int SHIFT_BITS   = 5;

	localparam logic [COUNT_BITS-1:0] NUM_PIXELS_RST = COUNT_BITS'(307200);

	localparam logic [SHIFT_BITS-1:0] SHIFT_STEP      = SHIFT_BITS'(3);
	localparam logic [SHIFT_BITS-1:0] SHIFT_LAST_FULL = SHIFT_BITS'(27);
	localparam logic [SHIFT_BITS-1:0] SHIFT_LAST_PART = SHIFT_BITS'(30);
	localparam logic [SHIFT_BITS-1:0] SHIFT_SAT       = SHIFT_BITS'(31);

	localparam int WQ_DEPTH = 2;
	localparam int WQ_AW    = $clog2(WQ_DEPTH);
	localparam int RQ_DEPTH = 2;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	typedef enum logic [1:0] {
		PH_ZEROS,
		PH_NONZEROS,
		PH_DELTAS
	} phase_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic [NIBBLES-1:0]   term;
	} word_item_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel;
		logic [COUNT_BITS-1:0] count;
		logic                  frame_end;
		logic                  last;
	} result_t;

	typedef struct packed {
		logic busy;
		logic hold_valid;
	} back_status_t;

endpackage

@@ rtl/rvl_dd_outq.sv @@
// result queue driving the output channel
module rvl_dd_outq import rvl_dd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_push,
	input  result_t               res,
	output logic                  res_full,
	output logic                  res_empty,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIXEL_BITS-1:0] pixel_value,
	output logic [COUNT_BITS-1:0] repeat_count,
	output logic                  frame_end,
	output logic                  last
);

	result_t          mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_ptr_q;
	logic [RQ_AW-1:0] rd_ptr_q;
	logic [RQ_AW:0]   cnt_q;
	logic             pop;
	result_t          head;

	assign res_full  = (cnt_q == (RQ_AW+1)'(RQ_DEPTH));
	assign res_empty = (cnt_q == '0);
	assign out_valid = !res_empty;
	assign pop       = out_valid && !out_stall;
	assign head      = mem_q[rd_ptr_q];

	assign pixel_value  = head.pixel;
	assign repeat_count = head.count;
	assign frame_end    = head.frame_end;
	assign last         = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (res_push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !res_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push)
			mem_q[wr_ptr_q] <= res;
	end

endmodule

@@ rtl/rvl_dd_front.sv @@
// input side: word queue with nibble terminator marks
module rvl_dd_front import rvl_dd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [WORD_BITS-1:0] packed_word,
	output logic                 wq_valid,
	output word_item_t           wq_item,
	input  logic                 wq_pop
);

	word_item_t       mem_q [WQ_DEPTH];
	logic [WQ_AW-1:0] wr_ptr_q;
	logic [WQ_AW-1:0] rd_ptr_q;
	logic [WQ_AW:0]   cnt_q;
	logic             push;
	word_item_t       item;

	// a nibble with its top bit clear closes a value
	always_comb begin
		item.word = packed_word;
		for (int i = 0; i < NIBBLES; i++)
			item.term[i] = ~packed_word[NIB_BITS*i + NIB_BITS - 1];
	end

	assign in_stall = (cnt_q == (WQ_AW+1)'(WQ_DEPTH));
	assign push     = in_valid && !in_stall;
	assign wq_valid = (cnt_q != '0);
	assign wq_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (wq_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !wq_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (wq_pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= item;
	end

endmodule

@@ rtl/rvl_dd_back.sv @@
// nibble decoder: one nibble a cycle unless stalled by a full result queue, run and delta handling, result hold stage
module rvl_dd_back import rvl_dd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wq_valid,
	input  word_item_t            wq_item,
	output logic                  wq_pop,
	input  logic                  cfg_wr,
	input  logic [COUNT_BITS-1:0] cfg_data,
	output logic                  res_push,
	output result_t               res,
	input  logic                  res_full,
	output back_status_t          status
);

	logic                    busy_q, busy_d;
	logic [WORD_BITS-1:0]    word_q, word_d;
	logic [NIBBLES-1:0]      term_q, term_d;
	logic [NIB_IDX_BITS-1:0] idx_q, idx_d;
	phase_t                  phase_q, phase_d;
	logic [ACC_BITS-1:0]     accum_q, accum_d;
	logic [SHIFT_BITS-1:0]   shift_q, shift_d;
	logic [COUNT_BITS-1:0]   nzl_q, nzl_d;
	logic [PIXEL_BITS-1:0]   prev_q, prev_d;
	logic [COUNT_BITS-1:0]   pl_q, pl_d;
	logic [COUNT_BITS-1:0]   npix_q, npix_d;
	result_t                 hold_q, hold_d;
	logic                    hold_valid_q, hold_valid_d;

	logic [NIB_BITS-1:0]   nib;
	logic                  is_term;
	logic                  adv;
	logic [ACC_BITS-1:0]   accum_or;
	logic [SHIFT_BITS-1:0] shift_inc;
	logic [COUNT_BITS-1:0] clamp;
	logic [COUNT_BITS-1:0] pl_after;
	logic [PIXEL_BITS-1:0] delta;
	logic [PIXEL_BITS-1:0] prev_sum;
	logic                  new_res;
	result_t               new_data;
	logic                  done;
	logic                  word_end;

	assign nib     = word_q[WORD_BITS-1 -: NIB_BITS];
	assign is_term = term_q[NIBBLES-1];
	// hold until the result queue can take the held result
	assign adv     = busy_q && !(hold_valid_q && res_full);

	assign accum_or  = (shift_q <= SHIFT_LAST_PART) ?
		(accum_q | (ACC_BITS'(nib[NIB_BITS-2:0]) << shift_q)) : accum_q;
	assign shift_inc = (shift_q <= SHIFT_LAST_FULL) ? shift_q + SHIFT_STEP : SHIFT_SAT;

	// run counts past the frame end are cut to what is left
	assign clamp    = (accum_or > ACC_BITS'(pl_q)) ? pl_q : accum_or[COUNT_BITS-1:0];
	assign pl_after = pl_q - clamp;

	// zigzag decode, only the pixel-wide bits matter
	assign delta    = accum_or[PIXEL_BITS:1] ^ {PIXEL_BITS{accum_or[0]}};
	assign prev_sum = prev_q + delta;

	assign status.busy       = busy_q;
	assign status.hold_valid = hold_valid_q;
	assign res               = hold_q;

	always_comb begin
		busy_d       = busy_q;
		word_d       = word_q;
		term_d       = term_q;
		idx_d        = idx_q;
		phase_d      = phase_q;
		accum_d      = accum_q;
		shift_d      = shift_q;
		nzl_d        = nzl_q;
		prev_d       = prev_q;
		pl_d         = pl_q;
		npix_d       = npix_q;
		hold_d       = hold_q;
		hold_valid_d = hold_valid_q;
		new_res      = 1'b0;
		new_data     = '0;
		done         = 1'b0;
		word_end     = 1'b0;
		wq_pop       = 1'b0;

		if (adv) begin
			word_d = word_q << NIB_BITS;
			term_d = term_q << 1;
			idx_d  = idx_q + 1'b1;
			if (!is_term) begin
				accum_d = accum_or;
				shift_d = shift_inc;
			end else begin
				accum_d = '0;
				shift_d = '0;
				case (phase_q)
					PH_ZEROS: begin
						pl_d    = pl_after;
						phase_d = PH_NONZEROS;
						if (clamp != '0) begin
							new_res            = 1'b1;
							new_data.count     = clamp;
							new_data.frame_end = (pl_after == '0);
						end
					end
					PH_NONZEROS: begin
						pl_d  = pl_after;
						nzl_d = clamp;
						if (clamp != '0)
							phase_d = PH_DELTAS;
						else if (pl_after == '0)
							done = 1'b1;
						else
							phase_d = PH_ZEROS;
					end
					PH_DELTAS: begin
						prev_d         = prev_sum;
						new_res        = 1'b1;
						new_data.pixel = prev_sum;
						new_data.count = COUNT_BITS'(1);
						if (nzl_q != '0)
							nzl_d = nzl_q - 1'b1;
						// last delta of the nonzero run
						if (nzl_q <= COUNT_BITS'(1)) begin
							new_data.frame_end = (pl_q == '0);
							if (pl_q == '0)
								done = 1'b1;
							else
								phase_d = PH_ZEROS;
						end
					end
					default: begin
						phase_d = PH_ZEROS;
					end
				endcase
			end
			if (done) begin
				phase_d = PH_ZEROS;
				accum_d = '0;
				shift_d = '0;
				nzl_d   = '0;
				prev_d  = '0;
				pl_d    = npix_q;
			end
			word_end = (idx_q == NIB_IDX_BITS'(NIBBLES-1)) || done;
		end

		// take the next word as soon as the current one ends
		if ((!busy_q || word_end) && wq_valid) begin
			wq_pop = 1'b1;
			busy_d = 1'b1;
			word_d = wq_item.word;
			term_d = wq_item.term;
			idx_d  = '0;
		end else if (word_end) begin
			busy_d = 1'b0;
		end

		// one result is held back until it is known whether it closes the word
		res_push = hold_valid_q && !res_full && (hold_q.last || (adv && new_res));
		if (adv && new_res) begin
			hold_d       = new_data;
			hold_d.last  = word_end;
			hold_valid_d = 1'b1;
		end else if (res_push) begin
			hold_valid_d = 1'b0;
		end else if (word_end && hold_valid_q) begin
			hold_d.last = 1'b1;
		end

		if (cfg_wr) begin
			npix_d  = cfg_data;
			phase_d = PH_ZEROS;
			accum_d = '0;
			shift_d = '0;
			nzl_d   = '0;
			prev_d  = '0;
			pl_d    = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			idx_q        <= '0;
			phase_q      <= PH_ZEROS;
			accum_q      <= '0;
			shift_q      <= '0;
			nzl_q        <= '0;
			prev_q       <= '0;
			pl_q         <= NUM_PIXELS_RST;
			npix_q       <= NUM_PIXELS_RST;
			hold_valid_q <= 1'b0;
		end else begin
			busy_q       <= busy_d;
			idx_q        <= idx_d;
			phase_q      <= phase_d;
			accum_q      <= accum_d;
			shift_q      <= shift_d;
			nzl_q        <= nzl_d;
			prev_q       <= prev_d;
			pl_q         <= pl_d;
			npix_q       <= npix_d;
			hold_valid_q <= hold_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
		term_q <= term_d;
		hold_q <= hold_d;
	end

endmodule

@@ rtl/rvl_depth_decompressor.sv @@
// the decoder takes one nibble a cycle unless stalled by a full result queue
// results leave at up to one per cycle while out_stall is low, through a two-entry result queue
// reset clears all control state and loads num_pixels with 307200
// cfg_ready is high only while no word or result is in flight
module rvl_depth_decompressor import rvl_dd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [WORD_BITS-1:0]  packed_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIXEL_BITS-1:0] pixel_value,
	output logic [COUNT_BITS-1:0] repeat_count,
	output logic                  frame_end,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [COUNT_BITS-1:0] num_pixels
);

	logic         wq_valid;
	word_item_t   wq_item;
	logic         wq_pop;
	logic         res_push;
	result_t      res;
	logic         res_full;
	logic         res_empty;
	back_status_t status;
	logic         cfg_wr;

	assign cfg_ready = !wq_valid && !status.busy && !status.hold_valid && res_empty;
	assign cfg_wr    = cfg_valid && cfg_ready;

	rvl_dd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.packed_word (packed_word),
		.wq_valid    (wq_valid),
		.wq_item     (wq_item),
		.wq_pop      (wq_pop)
	);

	rvl_dd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wq_valid (wq_valid),
		.wq_item  (wq_item),
		.wq_pop   (wq_pop),
		.cfg_wr   (cfg_wr),
		.cfg_data (num_pixels),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.status   (status)
	);

	rvl_dd_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_push     (res_push),
		.res          (res),
		.res_full     (res_full),
		.res_empty    (res_empty),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_value  (pixel_value),
		.repeat_count (repeat_count),
		.frame_end    (frame_end),
		.last         (last)
	);

endmodule

@@ rtl/rvl_dd_checker.sv @@
// port-level checks of the decompressor, bound to the top level
`include "assert_macros.svh"

module rvl_dd_checker import rvl_dd_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [PIXEL_BITS-1:0] pixel_value,
	input logic [COUNT_BITS-1:0] repeat_count,
	input logic                  frame_end,
	input logic                  last,
	input logic                  cfg_ready
);

	// a stalled request keeps valid and its payload
	`RVL_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`RVL_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(repeat_count) && $stable(pixel_value) && $stable(frame_end) && $stable(last))
	// every result covers at least one pixel
	`RVL_ASSERT_IMP(a_count_nonzero, clk, arst_n, out_valid, repeat_count != '0)
	// nonzero pixels come one at a time
	`RVL_ASSERT_IMP(a_pixel_single, clk, arst_n, out_valid && pixel_value != '0, repeat_count == COUNT_BITS'(1))
	// configuration opens only with nothing left to deliver
	`RVL_ASSERT_IMP(a_cfg_idle, clk, arst_n, cfg_ready, !out_valid)

endmodule

bind rvl_depth_decompressor rvl_dd_checker u_rvl_dd_checker (.*);
